// ===== hdl/line_downscale_resampler_top_macros.svh =====
// Assertion macros for the line resampler.
`ifndef LINE_DOWNSCALE_RESAMPLER_TOP_MACROS_SVH
`define LINE_DOWNSCALE_RESAMPLER_TOP_MACROS_SVH

// Check that an implication holds on every clock edge outside reset.
`define LDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: label failed");

// Check that an implication holds in the cycle after its antecedent.
`define LDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

// ===== hdl/ldr_pkg.sv =====
`default_nettype none
package ldr_pkg;
  localparam int unsigned LenW = 13;
  localparam int unsigned PosW = 12;
  localparam int unsigned ChW = 16;
  localparam int unsigned WgtW = 24;
  localparam int unsigned SumW = 40;
  localparam int unsigned QuoW = 17;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [0:0] RegSrcLen = 1'b0;
  localparam logic [0:0] RegDstLen = 1'b1;

  // One classified beat: pixel plus its weights and the control decisions.
  typedef struct packed {
    logic [ChW-1:0]  red;
    logic [ChW-1:0]  green;
    logic [ChW-1:0]  blue;
    logic [PosW-1:0] w0;
    logic [PosW-1:0] w1;
    logic            use_high;
    logic            shift;
    logic            last;
    logic [PosW-1:0] low_pos;
    logic [PosW-1:0] new_pos;
  } cmd_t;

  // Division job: three sums over one weight.
  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
    logic [WgtW-1:0] weight;
    logic [PosW-1:0] pos;
    logic            line_done;
    logic            run_end;
  } job_t;
endpackage
`default_nettype wire

// ===== hdl/ldr_if.sv =====
`default_nettype none
interface ldr_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface ldr_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [11:0] out_position;
  logic        line_done;
  logic        run_end;
  modport source (output valid, output red, output green, output blue,
                  output out_position, output line_done, output run_end, input ready);
  modport sink (input valid, input red, input green, input blue,
                input out_position, input line_done, input run_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/line_downscale_resampler_top.sv =====
// An accepted pixel passes the command FIFO, then the accumulator (multiply,
// add and emit states), then the bit-serial divider that makes each output beat.
// The accumulator takes a new pixel only once it is done with the last; every
// output beat holds the bit-serial divider, which then sets the rate.
// Reset: asynchronous, active low; lengths return to 2 and the line restarts.
// Any configuration write also restarts the line.
`default_nettype none
module line_downscale_resampler_top import ldr_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ldr_pix_if.sink                  pix_in,
  ldr_res_if.source                res_out,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  logic [LenW-1:0] src_q, dst_q;
  logic            wr, clear;
  logic            cv, cr, qv, qr, jv, jr;
  cmd_t            cmd, qcmd;
  job_t            job;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign clear = wr;

  // Decode register reads.
  always_comb begin
    prdata = paddr[2] == RegDstLen ? 32'(dst_q) : 32'(src_q);
  end

  // Hold the configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= LenW'(2); dst_q <= LenW'(2);
    end else if (clear) begin
      if (paddr[2] == RegSrcLen) src_q <= pwdata[LenW-1:0];
      else dst_q <= pwdata[LenW-1:0];
    end
  end

  ldr_front u_front (
    .clk_i, .rst_ni, .clear_i(clear), .src_len_i(src_q), .dst_len_i(dst_q),
    .in_valid_i(pix_in.valid), .in_ready_o(pix_in.ready),
    .red_i(pix_in.red), .green_i(pix_in.green), .blue_i(pix_in.blue),
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_o(cmd)
  );

  ldr_fifo #(.Width($bits(cmd_t))) u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(cv), .wr_ready_o(cr), .wr_data_i(cmd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qcmd)
  );

  ldr_accum u_accum (
    .clk_i, .rst_ni, .clear_i(clear), .cmd_valid_i(qv), .cmd_ready_o(qr),
    .cmd_i(qcmd), .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  ldr_div u_div (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .res_valid_o(res_out.valid), .res_ready_i(res_out.ready),
    .red_o(res_out.red), .green_o(res_out.green), .blue_o(res_out.blue),
    .pos_o(res_out.out_position), .line_done_o(res_out.line_done),
    .run_end_o(res_out.run_end)
  );
endmodule
`default_nettype wire

// ===== hdl/ldr_front.sv =====
`default_nettype none
module ldr_front import ldr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire logic [LenW-1:0] src_len_i,
  input  wire logic [LenW-1:0] dst_len_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [ChW-1:0]  red_i,
  input  wire logic [ChW-1:0]  green_i,
  input  wire logic [ChW-1:0]  blue_i,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_ready_i,
  output cmd_t                 cmd_o
);
  logic [PosW-1:0] cnt_q, cnt_d, low_q, low_d, rem_q, rem_d;
  logic [LenW-1:0] l_eff, m_eff, d_eff;
  logic [LenW:0]   r_sum;
  logic [PosW-1:0] q, r;
  logic            fire;

  // Clamp the lengths.
  always_comb begin
    l_eff = src_len_i;
    if (l_eff < LenW'(2)) l_eff = LenW'(2);
    if (l_eff > LenW'(4096)) l_eff = LenW'(4096);
    m_eff = dst_len_i;
    if (m_eff < LenW'(1)) m_eff = LenW'(1);
    if (m_eff > l_eff) m_eff = l_eff;
    d_eff = l_eff - LenW'(1);
  end

  // Place the source pixel and derive its weights.
  always_comb begin
    r_sum = {1'b0, LenW'(rem_q)} + {1'b0, m_eff - LenW'(1)};
    q = low_q;
    r = '0;
    if (cnt_q != '0) begin
      if (r_sum >= {1'b0, d_eff}) begin
        r = PosW'(r_sum - {1'b0, d_eff});
        q = low_q + PosW'(1);
      end else begin
        r = PosW'(r_sum);
      end
    end else begin
      q = '0;
    end
    fire = in_valid_i && in_ready_o;
    cmd_o.red = red_i;
    cmd_o.green = green_i;
    cmd_o.blue = blue_i;
    cmd_o.w0 = PosW'(d_eff - LenW'(r));
    cmd_o.w1 = r;
    cmd_o.use_high = ({1'b0, q} + LenW'(1)) < m_eff;
    cmd_o.shift = q != low_q;
    cmd_o.last = ({1'b0, cnt_q} + LenW'(1)) >= l_eff;
    cmd_o.low_pos = low_q;
    cmd_o.new_pos = q;
    in_ready_o = cmd_ready_i;
    cmd_valid_o = in_valid_i;
    cnt_d = cnt_q; low_d = low_q; rem_d = rem_q;
    if (fire) begin
      if (cmd_o.last) begin
        cnt_d = '0; low_d = '0; rem_d = '0;
      end else begin
        cnt_d = cnt_q + PosW'(1); low_d = q; rem_d = r;
      end
    end
  end

  // Hold the position state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; low_q <= '0; rem_q <= '0;
    end else if (clear_i) begin
      cnt_q <= '0; low_q <= '0; rem_q <= '0;
    end else begin
      cnt_q <= cnt_d; low_q <= low_d; rem_q <= rem_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ldr_fifo.sv =====
`default_nettype none
module ldr_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic [Width-1:0]      rd_data_o
);
  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];

  // Store the payload.
  always_ff @(posedge clk_i) begin
    if (wr_valid_i && wr_ready_o) mem_q[wp_q] <= wr_data_i;
  end

  // Advance the pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_valid_i && wr_ready_o) wp_q <= ~wp_q;
      if (rd_valid_o && rd_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_valid_i && wr_ready_o) - 2'(rd_valid_o && rd_ready_i);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ldr_accum.sv =====
`default_nettype none
module ldr_accum import ldr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic clear_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      job_valid_o,
  input  wire logic job_ready_i,
  output job_t      job_o
);
  typedef enum logic [1:0] {SMul, SAdd, SEmitLow, SEmitLast} state_e;
  state_e          state_q;
  cmd_t            cmd_q;
  logic [SumW-1:0] lo_q [3];
  logic [SumW-1:0] hi_q [3];
  logic [WgtW-1:0] lw_q, hw_q;
  logic [27:0]     p0_q [3];
  logic [27:0]     p1_q [3];
  logic            busy_q;
  logic [ChW-1:0]  px [3];

  assign px[0] = cmd_q.red;
  assign px[1] = cmd_q.green;
  assign px[2] = cmd_q.blue;
  assign cmd_ready_o = !busy_q;

  // Build the job on the low accumulator.
  always_comb begin
    job_valid_o = busy_q && (state_q == SEmitLow || state_q == SEmitLast);
    job_o.red = lo_q[0];
    job_o.green = lo_q[1];
    job_o.blue = lo_q[2];
    job_o.weight = lw_q;
    job_o.pos = state_q == SEmitLow ? cmd_q.low_pos : cmd_q.new_pos;
    job_o.line_done = state_q == SEmitLast;
    job_o.run_end = state_q == SEmitLast || !cmd_q.last;
  end

  // Sequence multiply, shift, add and emits per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      state_q <= SMul;
      lw_q <= '0; hw_q <= '0;
      for (int c = 0; c < 3; c++) begin
        lo_q[c] <= '0; hi_q[c] <= '0;
      end
    end else if (clear_i) begin
      busy_q <= 1'b0;
      state_q <= SMul;
      lw_q <= '0; hw_q <= '0;
      for (int c = 0; c < 3; c++) begin
        lo_q[c] <= '0; hi_q[c] <= '0;
      end
    end else if (!busy_q) begin
      if (cmd_valid_i) begin
        cmd_q <= cmd_i;
        busy_q <= 1'b1;
        state_q <= cmd_i.shift ? SEmitLow : SMul;
      end
    end else begin
      unique case (state_q)
        SEmitLow: begin
          if (job_ready_i) begin
            for (int c = 0; c < 3; c++) begin
              lo_q[c] <= hi_q[c]; hi_q[c] <= '0;
            end
            lw_q <= hw_q; hw_q <= '0;
            state_q <= SMul;
          end
        end
        SMul: begin
          for (int c = 0; c < 3; c++) begin
            p0_q[c] <= cmd_q.w0 * px[c];
            p1_q[c] <= cmd_q.use_high ? cmd_q.w1 * px[c] : 28'd0;
          end
          state_q <= SAdd;
        end
        SAdd: begin
          for (int c = 0; c < 3; c++) begin
            lo_q[c] <= lo_q[c] + SumW'(p0_q[c]);
            hi_q[c] <= hi_q[c] + SumW'(p1_q[c]);
          end
          lw_q <= lw_q + WgtW'(cmd_q.w0);
          if (cmd_q.use_high) hw_q <= hw_q + WgtW'(cmd_q.w1);
          if (cmd_q.last) state_q <= SEmitLast;
          else begin
            state_q <= SMul;
            busy_q <= 1'b0;
          end
        end
        SEmitLast: begin
          if (job_ready_i) begin
            for (int c = 0; c < 3; c++) begin
              lo_q[c] <= '0; hi_q[c] <= '0;
            end
            lw_q <= '0; hw_q <= '0;
            state_q <= SMul;
            busy_q <= 1'b0;
          end
        end
        default: state_q <= SMul;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ldr_div.sv =====
`default_nettype none
module ldr_div import ldr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output logic [ChW-1:0]  red_o,
  output logic [ChW-1:0]  green_o,
  output logic [ChW-1:0]  blue_o,
  output logic [PosW-1:0] pos_o,
  output logic            line_done_o,
  output logic            run_end_o
);
  // Restoring division, one quotient bit per cycle for all three channels.
  typedef enum logic [1:0] {SIdle, SRun, SOut} state_e;
  state_e          state_q;
  logic [SumW:0]   num_q [3];
  logic [SumW:0]   rem_q [3];
  logic [QuoW-1:0] quo_q [3];
  logic [WgtW-1:0] den_q;
  logic [5:0]      bit_q;
  logic [PosW-1:0] pos_q;
  logic            ld_q, re_q, zero_q;
  logic [SumW:0]   trial [3];

  assign job_ready_o = state_q == SIdle;
  assign res_valid_o = state_q == SOut;
  assign red_o = zero_q ? '0 : quo_q[0][ChW-1:0];
  assign green_o = zero_q ? '0 : quo_q[1][ChW-1:0];
  assign blue_o = zero_q ? '0 : quo_q[2][ChW-1:0];
  assign pos_o = pos_q;
  assign line_done_o = ld_q;
  assign run_end_o = re_q;

  always_comb begin
    for (int c = 0; c < 3; c++)
      trial[c] = {rem_q[c][SumW-1:0], num_q[c][SumW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (job_valid_i) begin
            for (int c = 0; c < 3; c++) begin
              rem_q[c] <= '0;
              quo_q[c] <= '0;
            end
            num_q[0] <= {1'b0, job_i.red} + (SumW+1)'(job_i.weight >> 1);
            num_q[1] <= {1'b0, job_i.green} + (SumW+1)'(job_i.weight >> 1);
            num_q[2] <= {1'b0, job_i.blue} + (SumW+1)'(job_i.weight >> 1);
            den_q <= job_i.weight;
            zero_q <= job_i.weight == '0;
            pos_q <= job_i.pos;
            ld_q <= job_i.line_done;
            re_q <= job_i.run_end;
            bit_q <= 6'(SumW + 1);
            state_q <= SRun;
          end
        end
        SRun: begin
          for (int c = 0; c < 3; c++) begin
            num_q[c] <= num_q[c] << 1;
            if (trial[c] >= (SumW+1)'(den_q)) begin
              rem_q[c] <= trial[c] - (SumW+1)'(den_q);
              quo_q[c] <= {quo_q[c][QuoW-2:0], 1'b1};
            end else begin
              rem_q[c] <= trial[c];
              quo_q[c] <= {quo_q[c][QuoW-2:0], 1'b0};
            end
          end
          bit_q <= bit_q - 6'd1;
          if (bit_q == 6'd1) state_q <= SOut;
        end
        SOut: if (res_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ldr_checker.sv =====
`default_nettype none
`include "line_downscale_resampler_top_macros.svh"
module ldr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic line_done_i,
  input wire logic run_end_i,
  input wire logic pready_i
);
  `LDR_ASSERT_IMP(a_done_ends_run, clk_i, rst_ni, out_valid_i && line_done_i, run_end_i)
  `LDR_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `LDR_ASSERT_IMP(a_pready_high, clk_i, rst_ni, 1'b1, pready_i)
endmodule

bind line_downscale_resampler_top ldr_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(res_out.valid),
  .out_ready_i(res_out.ready), .line_done_i(res_out.line_done),
  .run_end_i(res_out.run_end), .pready_i(pready)
);
`default_nettype wire

// ===== test/line_downscale_resampler_top_tb.sv =====
`default_nettype none
module line_downscale_resampler_top_tb;
  import ldr_pkg::*;

  localparam int unsigned ItemCount = 1250;

  // One output pixel as the block should produce it
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [11:0] pos;
    logic        line_done;
    logic        run_end;
  } pixel_res_t;

  // Directed row: pixel plus optional typed expectation
  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    bit          typed;
    pixel_res_t  exp_res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ldr_pix_if pix_in ();
  ldr_res_if res_out ();

  line_downscale_resampler_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_in.sink),
    .res_out (res_out.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [12:0] src_len_q, dst_len_q;
  logic [11:0] src_cnt, low_idx, pos_rem;
  logic [39:0] low_acc [3];
  logic [39:0] high_acc [3];
  logic [23:0] low_wgt, high_wgt;

  pixel_res_t expected_pixels [$];
  int errors = 0;
  int res_seen = 0;
  int lines_done = 0;

  function automatic void clear_line();
    src_cnt = '0;
    low_idx = '0;
    pos_rem = '0;
    low_wgt = '0;
    high_wgt = '0;
    for (int c = 0; c < 3; c++) begin
      low_acc[c] = '0;
      high_acc[c] = '0;
    end
  endfunction

  function automatic pixel_res_t average_low(bit last);
    pixel_res_t p;
    logic [39:0] v [3];
    for (int c = 0; c < 3; c++) begin
      if (low_wgt != 0) v[c] = (low_acc[c] + low_wgt / 2) / low_wgt;
      else v[c] = '0;
    end
    p.red = v[0][15:0];
    p.green = v[1][15:0];
    p.blue = v[2][15:0];
    p.pos = low_idx;
    p.line_done = last;
    p.run_end = 1'b0;
    return p;
  endfunction

  // Accumulate one source pixel and queue the outputs it completes
  function automatic int resample_pixel(logic [15:0] r_i, logic [15:0] g_i,
                                        logic [15:0] b_i);
    int unsigned l, m, d, q, r;
    logic [15:0] px [3];
    pixel_res_t outs [2];
    int n;
    l = src_len_q;
    if (l < 2) l = 2;
    if (l > 4096) l = 4096;
    m = dst_len_q;
    if (m < 1) m = 1;
    if (m > l) m = l;
    d = l - 1;
    n = 0;
    px[0] = r_i;
    px[1] = g_i;
    px[2] = b_i;
    if (src_cnt == 0) begin
      q = 0;
      r = 0;
    end else begin
      q = low_idx;
      r = pos_rem + (m - 1);
      if (r >= d) begin
        r -= d;
        q++;
      end
    end
    if (q != low_idx) begin
      outs[n] = average_low(1'b0);
      n++;
      for (int c = 0; c < 3; c++) begin
        low_acc[c] = high_acc[c];
        high_acc[c] = '0;
      end
      low_wgt = high_wgt;
      high_wgt = '0;
      low_idx = q[11:0];
    end
    for (int c = 0; c < 3; c++) low_acc[c] += 40'(d - r) * px[c];
    low_wgt += 24'(d - r);
    if (q + 1 < m) begin
      for (int c = 0; c < 3; c++) high_acc[c] += 40'(r) * px[c];
      high_wgt += 24'(r);
    end
    pos_rem = r[11:0];
    if (src_cnt + 1 >= l) begin
      outs[n] = average_low(1'b1);
      n++;
      clear_line();
    end else begin
      src_cnt++;
    end
    if (n > 0) outs[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) expected_pixels = {expected_pixels, outs[i]};
    return n;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drop the input beat
  task automatic idle_pix();
    pix_in.valid <= 1'b0;
  endtask

  // Register write: setup then access beat; drains the block first
  task automatic write_reg(logic [0:0] idx, logic [12:0] val);
    idle_pix();
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegSrcLen) src_len_q = val;
    else dst_len_q = val;
    clear_line();
  endtask

  // Offer one pixel; valid drops only when a gap comes before it
  task automatic send_pixel(logic [15:0] r_i, logic [15:0] g_i, logic [15:0] b_i);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.red <= r_i;
    pix_in.green <= g_i;
    pix_in.blue <= b_i;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    void'(resample_pixel(r_i, g_i, b_i));
  endtask

  // Compare every result beat with the oldest expectation
  always @(posedge clk_i) begin
    pixel_res_t e;
    if (rst_ni && res_out.valid && res_out.ready) begin
      res_seen++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result beat at position %0d", res_out.out_position);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (res_out.red !== e.red) begin
          $error("red_out expected %0d got %0d", e.red, res_out.red); errors++;
        end
        if (res_out.green !== e.green) begin
          $error("green_out expected %0d got %0d", e.green, res_out.green); errors++;
        end
        if (res_out.blue !== e.blue) begin
          $error("blue_out expected %0d got %0d", e.blue, res_out.blue); errors++;
        end
        if (res_out.out_position !== e.pos) begin
          $error("out_position expected %0d got %0d", e.pos, res_out.out_position);
          errors++;
        end
        if (res_out.line_done !== e.line_done) begin
          $error("line_done expected %0d got %0d", e.line_done, res_out.line_done);
          errors++;
        end
        if (res_out.run_end !== e.run_end) begin
          $error("run_end expected %0d got %0d", e.run_end, res_out.run_end);
          errors++;
        end
        if (e.line_done) lines_done++;
      end
    end
  end

  // Random back-pressure on the result side
  initial begin
    int n;
    res_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      res_out.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      n = gap_len();
      if (n > 0) begin
        res_out.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Typed expectation for a directed row, checked against the predictor
  task automatic send_row(dir_row_t row);
    pixel_res_t p;
    int n_prev;
    n_prev = expected_pixels.size();
    send_pixel(row.red, row.green, row.blue);
    if (row.typed) begin
      if (expected_pixels.size() == n_prev) begin
        $error("directed row: expected %h got no result", row.exp_res);
        errors++;
      end else begin
        p = expected_pixels[expected_pixels.size() - 1];
        if (p != row.exp_res) begin
          $error("directed row mismatch: expected %h got %h", row.exp_res, p);
          errors++;
        end
      end
    end
  endtask

  task automatic random_lines(int n_items, int max_len);
    int l, m;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      l = ($urandom_range(0, 19) == 0) ? $urandom_range(2, max_len) : $urandom_range(2, 24);
      m = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, l);
      write_reg(RegSrcLen, 13'(l));
      write_reg(RegDstLen, 13'(m));
      for (int i = 0; i < l && sent < n_items; i++) begin
        case ($urandom_range(0, 7))
          0: send_pixel(16'hffff, 16'h0000, 16'hffff);
          1: send_pixel(16'h0000, 16'hffff, 16'h0000);
          default: send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    pix_in.valid = 1'b0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_len_q = 13'd2;
    dst_len_q = 13'd2;
    clear_line();

    // Reset lengths 2 -> 2: the last pixel releases both outputs unchanged
    row = '{16'hffff, 16'h0000, 16'h1234, 1'b0, '0};
    rows = {rows, row};
    row = '{16'h0000, 16'hffff, 16'h8000, 1'b1, '{16'h0000, 16'hffff, 16'h8000, 12'd1,
           1'b1, 1'b1}};
    rows = {rows, row};
    foreach (rows[i]) send_row(rows[i]);
    rows.delete();

    // Single output pixel: plain rounded average of the line
    write_reg(RegSrcLen, 13'd3);
    write_reg(RegDstLen, 13'd1);
    row = '{16'h0000, 16'h0000, 16'hffff, 1'b0, '0};
    rows = {rows, row};
    row = '{16'h0001, 16'hffff, 16'hffff, 1'b0, '0};
    rows = {rows, row};
    row = '{16'h0000, 16'hffff, 16'hffff, 1'b0, '0};
    rows = {rows, row};
    foreach (rows[i]) send_row(rows[i]);
    rows.delete();
    // Out-of-range lengths: clamped to 2 and to the source length, then to 4096 and to 1
    write_reg(RegSrcLen, 13'd0);
    write_reg(RegDstLen, 13'd8191);
    for (int i = 0; i < 4; i++) send_pixel(16'(i * 16'h5555), 16'hffff, 16'h0000);
    write_reg(RegSrcLen, 13'd8191);
    write_reg(RegDstLen, 13'd0);
    for (int i = 0; i < 3; i++) send_pixel(16'hffff, 16'h0000, 16'hffff);
    // Two results from the last pixel: 5 -> 3 and 7 -> 4
    write_reg(RegSrcLen, 13'd5);
    write_reg(RegDstLen, 13'd3);
    for (int i = 0; i < 5; i++) send_pixel(16'($urandom), 16'hffff, 16'h0000);
    write_reg(RegSrcLen, 13'd7);
    write_reg(RegDstLen, 13'd4);
    for (int i = 0; i < 7; i++) send_pixel(16'($urandom), 16'($urandom), 16'($urandom));

    // Random lines, mostly short, a few up to the maximum length
    random_lines(ItemCount - 300, 300);
    write_reg(RegSrcLen, 13'd4096);
    write_reg(RegDstLen, 13'd4096);
    for (int i = 0; i < 4; i++) send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
    random_lines(300, 4096);

    idle_pix();
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d result beats over %0d completed lines, lengths 2..4096.",
             res_seen, lines_done);
    if (errors == 0) begin
      $display("PASS line_downscale_resampler_top");
    end else begin
      $display("FAIL line_downscale_resampler_top");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("FAIL line_downscale_resampler_top");
    $finish;
  end
endmodule
`default_nettype wire
